@@ rtl/nds_pkg.sv @@
package nds_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int unsigned MAX_DIRS_DEF  = 512;
  localparam int unsigned COMP_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned IDX_W = 9;   // entry_index, best_index
  localparam int unsigned CFG_W = 10;  // dirs_in_use

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_DIRS_IN_USE = '0;

  // Request kinds carried in tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } nds_state_e;

  typedef struct packed {
    logic issue;     // read one table entry this cycle
    logic out_load;  // move the finished result into the output register
  } nds_ctrl_t;

endpackage

@@ rtl/nds_dir_ram.sv @@
module nds_dir_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 48,
  parameter int unsigned AW    = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/nearest_direction_search_unit.sv @@
// Nearest direction search.
// Input stream (s_axis_*): tuser selects the request kind. A load request
// writes entry_index of the direction table with (vec_x, vec_y, vec_z) and
// gives no result. A query request compares the query vector with table
// entries 0 .. dirs_in_use-1 (at most MAX_DIRS) and gives one result on
// m_axis_*: the index and dot product of the entry with the largest dot
// product, the first one on a tie, or index 0 and -1.0 if no entry beats
// -1.0.
// A query reads one table entry per cycle from the table RAM; a multiply
// stage and an add stage follow the RAM read. One request is worked on at
// a time; loads and the next query are taken while a result still waits in
// the output register. A query that finishes while that register is still
// full waits until the receiver takes it. dirs_in_use is written over the
// APB port; the user does this only while the block is idle, which the
// block itself does not enforce. Reset clears dirs_in_use and all control
// state; table contents are undefined until loaded, and no clearing pass
// runs.
module nearest_direction_search_unit #(
  parameter int unsigned MAX_DIRS  = nds_pkg::MAX_DIRS_DEF,
  parameter int unsigned COMP_BITS = nds_pkg::COMP_BITS_DEF,
  localparam int unsigned IN_W  = ((nds_pkg::IDX_W + 3 * COMP_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((nds_pkg::IDX_W + 2 * COMP_BITS - 1 + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: entry_index, vec_x, vec_y, vec_z (from bit 0 up)
  input  logic [IN_W-1:0]              s_axis_tdata,
  // tuser: cmd
  input  logic                         s_axis_tuser,
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: best_index, best_dot (from bit 0 up)
  output logic [OUT_W-1:0]             m_axis_tdata,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nds_pkg::PADDR_W-1:0]  paddr,
  input  logic [nds_pkg::PDATA_W-1:0]  pwdata,
  output logic [nds_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  import nds_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_DIRS);
  localparam int unsigned CW   = $clog2(MAX_DIRS + 1);
  localparam int unsigned NW   = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned EW   = IDX_W + AW;
  localparam int unsigned VW   = 3 * COMP_BITS;
  localparam int unsigned PW   = 2 * COMP_BITS;
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned DW   = 2 * COMP_BITS - 1;
  localparam int unsigned FRAC = COMP_BITS - 2;
  localparam logic [SW-1:0] ONE_DOT = SW'(1) << (2 * FRAC);

  nds_state_e state_q, state_d;
  nds_ctrl_t  ctrl;

  logic [CFG_W-1:0] dirs_q;
  logic [CW-1:0]    cnt_q, n_q;
  logic [2:0]       v_q;
  logic [VW-1:0]    qvec_q;
  logic [AW-1:0]    idx0_q, idx1_q, idx2_q, best_idx_q;
  logic signed [PW-1:0] prod_q [3];
  logic signed [SW-1:0] sum_q, best_q;
  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  logic [IDX_W-1:0] in_idx;
  logic [VW-1:0]    in_vec;
  logic [EW-1:0]    idx_ext, bidx_ext;
  logic [NW-1:0]    cfg_ext;
  logic [CW-1:0]    n_clamp;
  logic             in_acc, load_we, query_go, cfg_wr, reg_hit, better;
  logic [VW-1:0]    rd_vec;
  logic signed [COMP_BITS-1:0] ent_c [3];
  logic signed [COMP_BITS-1:0] qry_c [3];
  logic signed [PW-1:0]        prod_d [3];

  // input field decode
  assign in_idx   = s_axis_tdata[IDX_W-1:0];
  assign in_vec   = s_axis_tdata[IDX_W +: VW];
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign idx_ext  = EW'(in_idx);
  assign load_we  = in_acc && (s_axis_tuser == CMD_LOAD) && (idx_ext < EW'(MAX_DIRS));
  assign query_go = in_acc && (s_axis_tuser == CMD_QUERY);

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_DIRS_IN_USE);
  assign cfg_wr  = psel & penable & pwrite & pready & reg_hit;
  assign prdata  = reg_hit ? PDATA_W'(dirs_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirs_q <= '0;
    end else if (cfg_wr) begin
      dirs_q <= pwdata[CFG_W-1:0];
    end
  end

  // entries searched, clamped to the table depth
  assign cfg_ext = NW'(dirs_q);
  assign n_clamp = (cfg_ext > NW'(MAX_DIRS)) ? CW'(MAX_DIRS) : cfg_ext[CW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (query_go) state_d = ST_SCAN;
      ST_SCAN:  if (cnt_q == n_q) state_d = ST_DRAIN;
      ST_DRAIN: if (v_q == '0) state_d = ST_DONE;
      ST_DONE:  if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_SCAN:  ctrl.issue    = (cnt_q != n_q);
      ST_DONE:  ctrl.out_load = !m_valid_q || m_axis_tready;
      default:  ctrl = '0;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      n_q       <= '0;
      v_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v_q     <= {v_q[1:0], ctrl.issue};
      if (query_go) begin
        cnt_q <= '0;
        n_q   <= n_clamp;
      end else if (ctrl.issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (ctrl.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // direction table
  nds_dir_ram #(
    .DEPTH (MAX_DIRS),
    .WIDTH (VW),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (in_vec),
    .re_i    (ctrl.issue),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rd_vec)
  );

  // per-component products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ent_c[i]  = $signed(rd_vec[i*COMP_BITS +: COMP_BITS]);
      qry_c[i]  = $signed(qvec_q[i*COMP_BITS +: COMP_BITS]);
      prod_d[i] = ent_c[i] * qry_c[i];
    end
  end

  // strict compare keeps the first entry among equals
  assign better = v_q[2] && (sum_q > best_q);

  // datapath: multiply, add, compare
  always_ff @(posedge clk_i) begin
    if (query_go) begin
      qvec_q <= in_vec;
    end
    if (ctrl.issue) begin
      idx0_q <= cnt_q[AW-1:0];
    end
    if (v_q[0]) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= prod_d[i];
      end
      idx1_q <= idx0_q;
    end
    if (v_q[1]) begin
      sum_q  <= {{2{prod_q[0][PW-1]}}, prod_q[0]}
              + {{2{prod_q[1][PW-1]}}, prod_q[1]}
              + {{2{prod_q[2][PW-1]}}, prod_q[2]};
      idx2_q <= idx1_q;
    end
    if (query_go) begin
      best_q     <= $signed(-ONE_DOT);
      best_idx_q <= '0;
    end else if (better) begin
      best_q     <= sum_q;
      best_idx_q <= idx2_q;
    end
  end

  // output register
  assign bidx_ext = EW'(best_idx_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      m_data_q <= OUT_W'({best_q[DW-1:0], bidx_ext[IDX_W-1:0]});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef ASSERT_OFF
  // a new request is taken only with the compare pipeline empty
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (v_q == '0))
    else $error("request taken while entries still in flight");

  // the scan never runs past the clamped count
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= n_q) && (n_q <= CW'(MAX_DIRS)))
    else $error("scan counter out of range");

  // a finished query always lands in the output register
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && (state_d == ST_IDLE) |=> m_valid_q)
    else $error("finished query lost");

  // reads are issued only while scanning
  a_issue_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.issue |-> (state_q == ST_SCAN) && !load_we)
    else $error("table read outside the scan");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import nds_pkg::*;

  localparam int unsigned MAX_DIRS  = MAX_DIRS_DEF;
  localparam int unsigned COMP_BITS = COMP_BITS_DEF;
  localparam int unsigned DOT_W     = 2 * COMP_BITS - 1;
  localparam int unsigned IN_W  = ((IDX_W + 3 * COMP_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((IDX_W + DOT_W + 7) / 8) * 8;

  localparam logic [PADDR_W-1:0] ADDR_DIRS_IN_USE = {REG_DIRS_IN_USE, 2'b00};
  // First address past the register map
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = ADDR_DIRS_IN_USE + 3'd4;

  typedef logic signed [COMP_BITS-1:0] comp_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [DOT_W-1:0] dot;
  } nearest_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // tdata: entry_index, vec_x, vec_y, vec_z (from bit 0 up)
  logic [IN_W-1:0] s_axis_tdata;
  // tuser: cmd
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // tdata: best_index, best_dot (from bit 0 up)
  logic [OUT_W-1:0] m_axis_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Shadow copy of the block's table and count register
  comp_t dir_tab [MAX_DIRS][3];
  logic [CFG_W-1:0] dirs_cfg = '0;

  nearest_t nearest_q [$];
  int unsigned err_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_left = 0;

  nearest_direction_search_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
    err_count++;
    if (err_count <= 10) begin
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    end
  endtask

  // Largest dot product over the entries in use; first entry wins a tie
  function automatic nearest_t find_nearest(comp_t qx, comp_t qy, comp_t qz);
    nearest_t res;
    longint best;
    longint dot;
    int unsigned n;
    best = -(longint'(1) << (2 * (COMP_BITS - 2)));
    res.idx = '0;
    n = (dirs_cfg > MAX_DIRS) ? MAX_DIRS : dirs_cfg;
    for (int unsigned d = 0; d < n; d++) begin
      dot = longint'(dir_tab[d][0]) * longint'(qx)
          + longint'(dir_tab[d][1]) * longint'(qy)
          + longint'(dir_tab[d][2]) * longint'(qz);
      if (dot > best) begin
        best = dot;
        res.idx = IDX_W'(d);
      end
    end
    res.dot = best[DOT_W-1:0];
    return res;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return comp_t'(-32768);
          1: return comp_t'(32767);
          2: return comp_t'(16384);
          3: return comp_t'(-16384);
          default: return comp_t'(0);
        endcase
      end
      1, 2: return comp_t'($urandom);
      default: return comp_t'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Offer one request, wait for it to be taken, then update the prediction
  task automatic issue_request(logic cmd, logic [IDX_W-1:0] idx, comp_t x, comp_t y, comp_t z);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_W - IDX_W - 3 * COMP_BITS){1'b0}}, z, y, x, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_LOAD) begin
      dir_tab[idx][0] = x;
      dir_tab[idx][1] = y;
      dir_tab[idx][2] = z;
    end else begin
      nearest_q.insert(nearest_q.size(), find_nearest(x, y, z));
    end
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_DIRS_IN_USE) dirs_cfg = data[CFG_W-1:0];
  endtask

  task automatic apb_read_check(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) flag_mismatch("dirs_in_use readback", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_dirs(int unsigned n);
    apb_write(ADDR_DIRS_IN_USE, n);
    apb_read_check(ADDR_DIRS_IN_USE, n & ((1 << CFG_W) - 1));
  endtask

  // Empty table, ties, out-of-range components and no qualifying entry
  task automatic test_special_cases();
    apb_read_check(ADDR_DIRS_IN_USE, '0);
    // nothing in use right after reset
    issue_request(CMD_QUERY, '1, 16384, 0, 0);
    issue_request(CMD_LOAD, 0, 16384, 0, 0);
    issue_request(CMD_LOAD, 1, 0, 16384, 0);
    issue_request(CMD_LOAD, 2, 0, 0, 16384);
    issue_request(CMD_LOAD, 3, -16384, 0, 0);
    issue_request(CMD_LOAD, 4, 16384, 0, 0);
    issue_request(CMD_LOAD, 5, -16384, -16384, -16384);
    issue_request(CMD_LOAD, 6, 32767, 32767, 32767);
    issue_request(CMD_LOAD, 7, -32768, -32768, -32768);
    issue_request(CMD_LOAD, 511, -32768, 32767, 0);
    wait_idle();
    // entries 0 and 4 tie; query orthogonal to all but one
    set_dirs(5);
    issue_request(CMD_QUERY, 0, 16384, 0, 0);
    issue_request(CMD_QUERY, 0, 0, -16384, 0);
    issue_request(CMD_QUERY, 0, -16384, 0, 0);
    wait_idle();
    // full-scale components make the reported dot product wrap
    set_dirs(8);
    issue_request(CMD_QUERY, 0, -32768, -32768, -32768);
    issue_request(CMD_QUERY, 0, 32767, 32767, 32767);
    issue_request(CMD_QUERY, 0, 0, 0, 0);
    wait_idle();
    // dot of exactly -1.0 does not qualify, nor does one below it
    set_dirs(1);
    issue_request(CMD_QUERY, 0, -16384, 0, 0);
    issue_request(CMD_LOAD, 0, -32768, -32768, -32768);
    issue_request(CMD_QUERY, 0, 16384, 16384, 16384);
    wait_idle();
  endtask

  // Whole table loaded; largest counts, clamped counts and an unmapped write
  task automatic test_full_table();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (int unsigned e = 0; e < MAX_DIRS; e++) begin
      issue_request(CMD_LOAD, IDX_W'(e), rand_comp(), rand_comp(), rand_comp());
    end
    wait_idle();
    set_dirs(MAX_DIRS);
    repeat (4) issue_request(CMD_QUERY, 9'($urandom), rand_comp(), rand_comp(), rand_comp());
    wait_idle();
    set_dirs((1 << CFG_W) - 1);
    apb_write(ADDR_UNMAPPED, '1);
    apb_read_check(ADDR_DIRS_IN_USE, (1 << CFG_W) - 1);
    repeat (3) issue_request(CMD_QUERY, 9'($urandom), rand_comp(), rand_comp(), rand_comp());
    wait_idle();
    set_dirs(600);
    repeat (2) issue_request(CMD_QUERY, 9'($urandom), rand_comp(), rand_comp(), rand_comp());
    wait_idle();
    set_dirs(MAX_DIRS - 1);
    repeat (2) issue_request(CMD_QUERY, 9'($urandom), rand_comp(), rand_comp(), rand_comp());
    wait_idle();
  endtask

  // Receiver holds off long enough for queries to back up into the input
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_dirs(8);
    rx_hold_left <= 400;
    repeat (16) issue_request(CMD_QUERY, 9'($urandom), rand_comp(), rand_comp(), rand_comp());
    wait_idle();
  endtask

  // Mixed loads and queries, two count settings per idle pattern
  task automatic test_random_mix(int unsigned tx_pct, int unsigned rx_pct, int unsigned count);
    int unsigned n;
    logic [IDX_W-1:0] idx;
    comp_t v [3];
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int sub = 0; sub < 2; sub++) begin
      wait_idle();
      if (sub == 0) n = $urandom_range(1, 32);
      else n = ($urandom_range(3) == 0) ? 0 : $urandom_range(2, 64);
      set_dirs(n);
      repeat (count) begin
        if ($urandom_range(99) < 45) begin
          // loads mostly land inside the searched range
          idx = ($urandom_range(3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(n + 1));
          if ($urandom_range(7) == 0) begin
            v = dir_tab[$urandom_range(MAX_DIRS - 1)];
          end else begin
            v[0] = rand_comp();
            v[1] = rand_comp();
            v[2] = rand_comp();
          end
          issue_request(CMD_LOAD, idx, v[0], v[1], v[2]);
        end else begin
          // some queries point straight at a table entry
          if (n != 0 && $urandom_range(5) == 0) begin
            v = dir_tab[$urandom_range(n - 1)];
          end else begin
            v[0] = rand_comp();
            v[1] = rand_comp();
            v[2] = rand_comp();
          end
          issue_request(CMD_QUERY, IDX_W'($urandom), v[0], v[1], v[2]);
        end
      end
    end
    wait_idle();
  endtask

  // Result receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left  <= rx_hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin : check_result
    nearest_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (nearest_q.size() == 0) begin
        flag_mismatch("result with none pending", 0, m_axis_tdata);
      end else begin
        want = nearest_q.pop_front();
        if (m_axis_tdata[IDX_W-1:0] !== want.idx) begin
          flag_mismatch("best_index", want.idx, m_axis_tdata[IDX_W-1:0]);
        end
        if (m_axis_tdata[IDX_W +: DOT_W] !== want.dot) begin
          flag_mismatch("best_dot", want.dot, m_axis_tdata[IDX_W +: DOT_W]);
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_LOAD;
    m_axis_tready <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_full_table();
    test_backpressure();
    test_random_mix(0, 0, 75);
    test_random_mix(81, 0, 75);
    test_random_mix(0, 81, 75);
    test_random_mix(37, 37, 75);

    wait_idle();
    repeat (32) @(posedge clk_i);
    err_count += nearest_q.size();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
